// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the keystream cipher block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tkc_pkg.sv =====
// Package with constants, codes and control types of the keystream cipher block.
`default_nettype none

package tkc_pkg;

  localparam int MAX_SLICE = 4096;
  localparam int IDX_W     = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int VARIANT_W  = 2;

  localparam logic [WORD_W-1:0] GOLDEN      = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MULT_A      = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MULT_B      = 64'h94D049BB133111EB;
  localparam logic [WORD_W-1:0] KDF_SALT    = 64'h544945524B445946;
  localparam logic [WORD_W-1:0] STREAM_SALT = 64'h53545245414D5F5F;
  localparam logic [WORD_W-1:0] TAG_SALT_V0 = 64'h005441475F4B4559;
  localparam logic [WORD_W-1:0] TAG_SALT_V1 = 64'h0005441475F56310;
  localparam logic [WORD_W-1:0] TAG_SALT_V2 = 64'h0005441475F56320;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHARED_SECRET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_VARIANT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE  = 3'd4;

  // Tag variants.
  localparam logic [VARIANT_W-1:0] VARIANT_64 = 2'd0;
  localparam logic [VARIANT_W-1:0] VARIANT_16 = 2'd1;

  // What a mix result is used for.
  localparam logic [1:0] PUR_KEY    = 2'd0;
  localparam logic [1:0] PUR_STREAM = 2'd1;
  localparam logic [1:0] PUR_HMIX   = 2'd2;
  localparam logic [1:0] PUR_TAG    = 2'd3;

  // Operand selection for the shared multiplier.
  localparam logic [1:0] MSEL_PUB_B = 2'd0;
  localparam logic [1:0] MSEL_TIER  = 2'd1;
  localparam logic [1:0] MSEL_MIX_A = 2'd2;
  localparam logic [1:0] MSEL_MIX_B = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       seed_fold;
    logic       mix_write;
    logic [1:0] purpose;
    logic       absorb_pre;
    logic       absorb_fold;
    logic       out_load;
  } tkc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic last;
    logic do_mix;
    logic out_free;
  } tkc_status_t;

endpackage

`default_nettype wire

// ===== src/tkc_if.sv =====
// Channel interfaces of the keystream cipher block: input, result and configuration.
`default_nettype none

interface tkc_in_if import tkc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] tier;
  logic              first;
  logic              last;

  modport source (output valid, data_byte, tier, first, last, input ready);
  modport sink   (input valid, data_byte, tier, first, last, output ready);
endinterface

interface tkc_out_if import tkc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [WORD_W-1:0] tag;
  logic              tag_valid;
  logic              end_of_slice;

  modport source (output valid, out_byte, tag, tag_valid, end_of_slice, input ready);
  modport sink   (input valid, out_byte, tag, tag_valid, end_of_slice, output ready);
endinterface

interface tkc_cfg_if import tkc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/tkc_mul.sv =====
// Shared 64x64 low-half multiplier built from one 32x32 multiplier in three steps.
`default_nettype none

module tkc_mul import tkc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] prod,
  output logic              done
);

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;

  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W-1:0] acc;
  logic [1:0]        phase;
  logic              busy;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;
  logic [WORD_W-1:0] pp;

  // Only the low half of each cross product reaches the low 64 bits.
  always_comb begin
    case (phase)
      PH_LL: begin
        mx = a_r[HALF_W-1:0];
        my = b_r[HALF_W-1:0];
      end
      PH_LH: begin
        mx = a_r[HALF_W-1:0];
        my = b_r[WORD_W-1:HALF_W];
      end
      default: begin
        mx = a_r[WORD_W-1:HALF_W];
        my = b_r[HALF_W-1:0];
      end
    endcase
    pp = WORD_W'(mx) * WORD_W'(my);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_LL;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      phase <= PH_LL;
    end else if (busy) begin
      if (phase == PH_HL) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      phase <= phase + 2'd1;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy) begin
      if (phase == PH_LL) begin
        acc <= pp;
      end else begin
        acc <= acc + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

// ===== src/tkc_datapath.sv =====
// Datapath: configuration, key, keystream and tag registers, mix logic and result register.
`default_nettype none

module tkc_datapath import tkc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  tkc_cmd_t              cmd,
  output tkc_status_t           status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [BYTE_W-1:0]     tier,
  input  logic                  last,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_byte,
  output logic [WORD_W-1:0]     tag,
  output logic                  tag_valid,
  output logic                  end_of_slice
);

  logic [HALF_W-1:0]    shared_secret;
  logic [HALF_W-1:0]    public_a;
  logic [HALF_W-1:0]    public_b;
  logic [VARIANT_W-1:0] tag_variant;
  logic                 decrypt_mode;

  logic [WORD_W-1:0] stream_state;
  logic [WORD_W-1:0] tag_acc;
  logic [IDX_W-1:0]  byte_index;
  logic [IDX_W-1:0]  byte_index_next;

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] tier_r;
  logic              last_r;
  logic [WORD_W-1:0] seed;
  logic [BYTE_W-1:0] ob_r;
  logic [WORD_W-1:0] tag_r;
  logic [WORD_W-1:0] absorb_t;
  logic [WORD_W-1:0] absorb_c;

  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] prod;
  logic              mul_done;

  logic [WORD_W-1:0] mix_src;
  logic [WORD_W-1:0] mix_add;
  logic [WORD_W-1:0] mix_out;
  logic [WORD_W-1:0] tag_salt;
  logic [IDX_W:0]    idx_inc;
  logic [15:0]       idx_ext;
  logic [BYTE_W-1:0] absorb_byte;

  tkc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  always_comb begin
    idx_inc = {1'b0, byte_index} + (IDX_W + 1)'(1);
    case (cmd.purpose)
      PUR_KEY:    mix_src = seed;
      PUR_STREAM: mix_src = stream_state;
      PUR_HMIX:   mix_src = tag_acc;
      default:    mix_src = tag_acc ^ WORD_W'(idx_inc);
    endcase
    mix_add = mix_src + GOLDEN;
    mix_out = prod ^ (prod >> 31);

    case (cmd.mul_sel)
      MSEL_PUB_B: begin
        mul_a = WORD_W'(public_b);
        mul_b = GOLDEN;
      end
      MSEL_TIER: begin
        mul_a = WORD_W'(tier_r);
        mul_b = MULT_A;
      end
      MSEL_MIX_A: begin
        mul_a = mix_add ^ (mix_add >> 30);
        mul_b = MULT_A;
      end
      default: begin
        mul_a = prod ^ (prod >> 27);
        mul_b = MULT_B;
      end
    endcase

    case (tag_variant)
      VARIANT_64: tag_salt = TAG_SALT_V0;
      VARIANT_16: tag_salt = TAG_SALT_V1;
      default:    tag_salt = TAG_SALT_V2;
    endcase

    idx_ext = 16'(byte_index);
    case (tag_variant)
      VARIANT_64: status.do_mix = (idx_ext[5:0] == 6'h3F);
      VARIANT_16: status.do_mix = (idx_ext[3:0] == 4'hF);
      default:    status.do_mix = 1'b1;
    endcase

    absorb_byte = decrypt_mode ? data_r : ob_r;

    if (byte_index == IDX_W'(MAX_SLICE - 1)) begin
      byte_index_next = '0;
    end else begin
      byte_index_next = byte_index + IDX_W'(1);
    end

    status.mul_done = mul_done;
    status.last     = last_r;
    status.out_free = !out_valid || out_ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_secret <= '0;
      public_a      <= '0;
      public_b      <= '0;
      tag_variant   <= VARIANT_16;
      decrypt_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHARED_SECRET: shared_secret <= cfg_data;
        CFG_PUBLIC_A:      public_a      <= cfg_data;
        CFG_PUBLIC_B:      public_b      <= cfg_data;
        CFG_TAG_VARIANT:   tag_variant   <= cfg_data[VARIANT_W-1:0];
        CFG_DECRYPT_MODE:  decrypt_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Slice state: keystream, running tag and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_state <= '0;
      tag_acc      <= '0;
      byte_index   <= '0;
    end else begin
      if (cmd.mix_write) begin
        case (cmd.purpose)
          PUR_KEY: begin
            stream_state <= mix_out ^ STREAM_SALT;
            tag_acc      <= mix_out ^ tag_salt;
            byte_index   <= '0;
          end
          PUR_STREAM: stream_state <= stream_state + GOLDEN;
          PUR_HMIX:   tag_acc      <= mix_out;
          default: ;
        endcase
      end
      if (cmd.absorb_fold) begin
        tag_acc <= tag_acc ^ (absorb_t + absorb_c);
      end
      if (cmd.out_load) begin
        byte_index <= byte_index_next;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r <= data_byte;
      tier_r <= tier;
      last_r <= last;
      seed   <= {shared_secret, public_a} ^ KDF_SALT;
    end
    if (cmd.seed_fold) begin
      seed <= seed ^ prod;
    end
    if (cmd.mix_write && cmd.purpose == PUR_STREAM) begin
      ob_r <= data_r ^ mix_out[BYTE_W-1:0];
    end
    if (cmd.mix_write && cmd.purpose == PUR_TAG) begin
      tag_r <= mix_out;
    end
    if (cmd.absorb_pre) begin
      absorb_t <= (tag_acc << 6) + (tag_acc >> 2);
      absorb_c <= GOLDEN + WORD_W'(absorb_byte) + WORD_W'(byte_index);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte     <= ob_r;
      tag          <= last_r ? tag_r : '0;
      tag_valid    <= last_r;
      end_of_slice <= last_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/tkc_ctrl.sv =====
// Controller state machine that sequences key derivation, mixing, absorption and output.
`default_nettype none

module tkc_ctrl import tkc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_first,
  output logic        in_ready,
  input  tkc_status_t status,
  output tkc_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KB_GO = 4'd1;
  localparam logic [3:0] S_KB_W  = 4'd2;
  localparam logic [3:0] S_KT_GO = 4'd3;
  localparam logic [3:0] S_KT_W  = 4'd4;
  localparam logic [3:0] S_M1_GO = 4'd5;
  localparam logic [3:0] S_M1_W  = 4'd6;
  localparam logic [3:0] S_M2_GO = 4'd7;
  localparam logic [3:0] S_M2_W  = 4'd8;
  localparam logic [3:0] S_MDONE = 4'd9;
  localparam logic [3:0] S_ABS1  = 4'd10;
  localparam logic [3:0] S_ABS2  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] purpose;
  logic [1:0] purpose_next;

  always_comb begin
    cmd          = '0;
    cmd.purpose  = purpose;
    state_next   = state;
    purpose_next = purpose;
    in_ready     = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_first) begin
            state_next = S_KB_GO;
          end else begin
            purpose_next = PUR_STREAM;
            state_next   = S_M1_GO;
          end
        end
      end
      S_KB_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_PUB_B;
        state_next    = S_KB_W;
      end
      S_KB_W: begin
        if (status.mul_done) begin
          cmd.seed_fold = 1'b1;
          state_next    = S_KT_GO;
        end
      end
      S_KT_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_TIER;
        state_next    = S_KT_W;
      end
      S_KT_W: begin
        if (status.mul_done) begin
          cmd.seed_fold = 1'b1;
          purpose_next  = PUR_KEY;
          state_next    = S_M1_GO;
        end
      end
      S_M1_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_MIX_A;
        state_next    = S_M1_W;
      end
      S_M1_W: begin
        if (status.mul_done) begin
          state_next = S_M2_GO;
        end
      end
      S_M2_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_MIX_B;
        state_next    = S_M2_W;
      end
      S_M2_W: begin
        if (status.mul_done) begin
          state_next = S_MDONE;
        end
      end
      S_MDONE: begin
        cmd.mix_write = 1'b1;
        case (purpose)
          PUR_KEY: begin
            purpose_next = PUR_STREAM;
            state_next   = S_M1_GO;
          end
          PUR_STREAM: state_next = S_ABS1;
          PUR_HMIX: begin
            if (status.last) begin
              purpose_next = PUR_TAG;
              state_next   = S_M1_GO;
            end else begin
              state_next = S_OUT;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_ABS1: begin
        cmd.absorb_pre = 1'b1;
        state_next     = S_ABS2;
      end
      S_ABS2: begin
        cmd.absorb_fold = 1'b1;
        if (status.do_mix) begin
          purpose_next = PUR_HMIX;
          state_next   = S_M1_GO;
        end else if (status.last) begin
          purpose_next = PUR_TAG;
          state_next   = S_M1_GO;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      purpose <= PUR_STREAM;
    end else begin
      state   <= state_next;
      purpose <= purpose_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tiered_keystream_cipher_with_tag_core.sv =====
// Top level of the tiered keystream cipher with keyed tag.
//
//   Channel  Role   Request carries
//   -------  -----  ------------------------------------------------------
//   din      sink   data_byte, tier, first, last
//   dout     source out_byte, tag, tag_valid, end_of_slice
//   cfg      sink   index, data (register write, always ready)
//
// One byte request is worked on at a time; a first byte adds key derivation,
// and each tag mix (periodic or final) that it triggers adds a splitmix round.
// Every 64-bit multiply runs on one shared 32x32 multiplier, and one splitmix
// round needs two of them. Reset is synchronous and active high; it clears the
// slice state and the result register and loads the configuration defaults. A
// held result register stalls only the final step of the next byte, which
// waits until the slot is free.
`default_nettype none
`include "assert_macros.svh"

module tiered_keystream_cipher_with_tag_core import tkc_pkg::*; (
  input logic      clk,
  input logic      rst,
  tkc_in_if.sink   din,
  tkc_out_if.source dout,
  tkc_cfg_if.sink  cfg
);

  tkc_cmd_t    cmd;
  tkc_status_t status;

  // The configuration registers are plain flops, so a write is always taken.
  assign cfg.ready = 1'b1;

  // The controller owns the handshake on the input side and steps the datapath
  // through key derivation, keystream mixing, tag absorption and output.
  tkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_first (din.first),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds every data register of the cipher and the result register
  // that drives the output channel.
  tkc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg.valid && cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .data_byte    (din.data_byte),
    .tier         (din.tier),
    .last         (din.last),
    .out_ready    (dout.ready),
    .out_valid    (dout.valid),
    .out_byte     (dout.out_byte),
    .tag          (dout.tag),
    .tag_valid    (dout.tag_valid),
    .end_of_slice (dout.end_of_slice)
  );

  // A result must never overwrite one that has not yet been taken.
  `CHECK_SAME(a_no_overwrite, cmd.out_load, !dout.valid || dout.ready, "result overwritten")

  // Only one byte is in flight, so an accepted request drops ready next cycle.
  `CHECK_NEXT(a_single_item, din.valid && din.ready, !din.ready, "second request taken early")

  // The final tag is computed only for the last byte of a slice.
  `CHECK_SAME(a_tag_on_last, cmd.mix_write && cmd.purpose == PUR_TAG, status.last, "tag without last")

  // The multiplier is never started in the cycle that takes a new request.
  `CHECK_SAME(a_mul_quiet, din.valid && din.ready, !cmd.mul_start, "multiply on accept")

endmodule

`default_nettype wire
